@@ rtl/mdc_pkg.sv @@
package mdc_pkg;

	// Grid geometry.
	localparam int MAX_SIDE = 64;
	localparam int COORD_W = $clog2(MAX_SIDE);
	localparam int SIDE_W = COORD_W + 1;
	localparam int CELL_W = 2 * COORD_W;
	localparam int CELLS = MAX_SIDE * MAX_SIDE;
	localparam int SIDE_RESET = 16;

	// Operation codes of an input transaction.
	localparam logic OP_BEGIN = 1'b0;
	localparam logic OP_STEP = 1'b1;

	// Walk directions as carried by a draw and by a back-pointer.
	typedef enum logic [1:0] {
		DIR_UP    = 2'd0,
		DIR_RIGHT = 2'd1,
		DIR_DOWN  = 2'd2,
		DIR_LEFT  = 2'd3
	} dir_t;

	// Event codes of a result transaction.
	typedef enum logic [1:0] {
		EV_CARVED    = 2'd0,
		EV_REJECTED  = 2'd1,
		EV_BACKTRACK = 2'd2,
		EV_DONE      = 2'd3
	} kind_t;

	// Which visited row the datapath reads.
	typedef enum logic [1:0] {
		RS_CUR,
		RS_UP,
		RS_DOWN
	} row_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic     take;
		logic     init;
		logic     clear_wr;
		logic     cap_cur;
		logic     cap_up;
		logic     cap_down;
		row_sel_t rsel;
		logic     commit;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic op_begin;
		logic finished;
		logic clear_last;
		logic out_free;
	} sts_t;

endpackage

@@ rtl/mdc_in_if.sv @@
interface mdc_in_if;
	logic       valid;
	logic       ready;
	logic       operation;
	logic [1:0] random_direction;

	modport source (output valid, operation, random_direction, input ready);
	modport sink (input valid, operation, random_direction, output ready);
endinterface

@@ rtl/mdc_out_if.sv @@
interface mdc_out_if;
	import mdc_pkg::*;

	logic               valid;
	logic               ready;
	logic [1:0]         event_kind;
	logic               wall_vertical;
	logic [COORD_W-1:0] wall_x;
	logic [COORD_W-1:0] wall_y;
	logic [COORD_W-1:0] cursor_x;
	logic [COORD_W-1:0] cursor_y;
	logic               done_res;

	modport source (output valid, event_kind, wall_vertical, wall_x, wall_y, cursor_x,
		cursor_y, done_res, input ready);
	modport sink (input valid, event_kind, wall_vertical, wall_x, wall_y, cursor_x,
		cursor_y, done_res, output ready);
endinterface

@@ rtl/mdc_cfg_if.sv @@
interface mdc_cfg_if;
	import mdc_pkg::*;

	logic              valid;
	logic              ready;
	logic [SIDE_W-1:0] maze_size;

	modport source (output valid, maze_size, input ready);
	modport sink (input valid, maze_size, output ready);
endinterface

@@ rtl/maze_dfs_carver_unit.sv @@
// Randomized depth-first maze carver for a square grid of up to 64 x 64 cells. Each input
// transaction is either a begin, which clears the visited map and puts the cursor at the
// start cell (size/2, 0), or a walk step carrying one random direction; every input gives
// exactly one result transaction reporting a carved wall, a rejected draw, a backtrack, or
// finished/begun, together with the cursor after the item. The maze size register is taken
// at the next begin. In a walk step the three grid rows around the cursor are fetched one
// after another through the single read port of the visited-row memory before the decision
// and write-back cycle. A begin runs the sweep that clears the 64 visited rows, one row per
// cycle. A finished result waits in an output register, so the next item is accepted while
// the previous result is still pending.
module maze_dfs_carver_unit (
	input  logic       clk,
	input  logic       arst_n,
	mdc_in_if.sink     in_ch,
	mdc_out_if.source  out_ch,
	mdc_cfg_if.sink    cfg_ch
);
	import mdc_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// The size register takes a write in any cycle.
	assign cfg_ch.ready = 1'b1;

	// Sequencer for the item in progress.
	mdc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_ch.valid),
		.in_ready(in_ch.ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	// Grid store, cursor and result register.
	mdc_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.operation       (in_ch.operation),
		.random_direction(in_ch.random_direction),
		.cfg_we          (cfg_ch.valid),
		.cfg_maze_size   (cfg_ch.maze_size),
		.cmd             (cmd),
		.sts             (sts),
		.out_ch          (out_ch)
	);
endmodule

@@ rtl/mdc_ram.sv @@
module mdc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ rtl/mdc_ctrl.sv @@
module mdc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  mdc_pkg::sts_t sts,
	output mdc_pkg::cmd_t cmd
);
	import mdc_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_CLEAR,
		ST_RD_CUR,
		ST_RD_UP,
		ST_RD_DOWN,
		ST_DECIDE
	} state_t;

	state_t state_q;
	state_t state_n;

	// Next state and command decode.
	always_comb begin
		state_n = state_q;
		cmd = '0;
		cmd.rsel = RS_CUR;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take = 1'b1;
					state_n = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				if (sts.op_begin) begin
					cmd.init = 1'b1;
					state_n = ST_CLEAR;
				end else if (sts.finished) begin
					state_n = ST_DECIDE;
				end else begin
					state_n = ST_RD_CUR;
				end
			end
			ST_CLEAR: begin
				cmd.clear_wr = 1'b1;
				if (sts.clear_last) begin
					state_n = ST_DECIDE;
				end
			end
			ST_RD_CUR: begin
				cmd.cap_cur = 1'b1;
				cmd.rsel = RS_UP;
				state_n = ST_RD_UP;
			end
			ST_RD_UP: begin
				cmd.cap_up = 1'b1;
				cmd.rsel = RS_DOWN;
				state_n = ST_RD_DOWN;
			end
			ST_RD_DOWN: begin
				cmd.cap_down = 1'b1;
				state_n = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_n = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end
endmodule

@@ rtl/mdc_datapath.sv @@
module mdc_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       operation,
	input  logic [1:0]                 random_direction,
	input  logic                       cfg_we,
	input  logic [mdc_pkg::SIDE_W-1:0] cfg_maze_size,
	input  mdc_pkg::cmd_t              cmd,
	output mdc_pkg::sts_t              sts,
	mdc_out_if.source                  out_ch
);
	import mdc_pkg::*;

	// Neighbor cell of (x, y) in direction d, packed as {row, column}.
	function automatic logic [CELL_W-1:0] step_cell(dir_t d, logic [COORD_W-1:0] x,
		logic [COORD_W-1:0] y);
		logic [COORD_W-1:0] nx;
		logic [COORD_W-1:0] ny;
		nx = x;
		ny = y;
		case (d)
			DIR_UP:    ny = y - COORD_W'(1);
			DIR_RIGHT: nx = x + COORD_W'(1);
			DIR_DOWN:  ny = y + COORD_W'(1);
			default:   nx = x - COORD_W'(1);
		endcase
		return {ny, nx};
	endfunction

	// Registered state.
	logic [SIDE_W-1:0]   maze_size_q;
	logic [SIDE_W-1:0]   side_q;
	logic [COORD_W-1:0]  x_q;
	logic [COORD_W-1:0]  y_q;
	logic                fin_q;
	logic                op_q;
	dir_t                dir_q;
	logic [MAX_SIDE-1:0] row_q;
	logic                up_q;
	logic                down_q;
	logic [COORD_W-1:0]  clr_q;
	logic                out_valid_q;
	kind_t               kind_q;
	logic                wv_q;
	logic [COORD_W-1:0]  wx_q;
	logic [COORD_W-1:0]  wy_q;
	logic [COORD_W-1:0]  cx_q;
	logic [COORD_W-1:0]  cy_q;
	logic                done_q;

	// Memory ports.
	logic                vis_we;
	logic [COORD_W-1:0]  vis_waddr;
	logic [MAX_SIDE-1:0] vis_wdata;
	logic [COORD_W-1:0]  vis_raddr;
	logic [MAX_SIDE-1:0] vis_rdata;
	logic [1:0]          bp_rdata;

	// Decision signals.
	logic [SIDE_W-1:0]   side_new;
	logic [SIDE_W-1:0]   x_ext;
	logic [SIDE_W-1:0]   y_ext;
	logic [3:0]          in_rng;
	logic [3:0]          seen;
	logic [3:0]          free;
	logic                at_start;
	logic [MAX_SIDE-1:0] row_set;
	logic [CELL_W-1:0]   carve_cell;
	logic [CELL_W-1:0]   back_cell;
	dir_t                back_dir;
	logic [COORD_W-1:0]  nxt_x;
	logic [COORD_W-1:0]  nxt_y;
	logic                nxt_fin;
	kind_t               nxt_kind;
	logic                nxt_wv;
	logic [COORD_W-1:0]  nxt_wx;
	logic [COORD_W-1:0]  nxt_wy;
	logic                mark_cur;
	logic                write_bp;

	// Size as used by a new maze, held to the supported range.
	always_comb begin
		if (maze_size_q < SIDE_W'(2)) begin
			side_new = SIDE_W'(2);
		end else if (maze_size_q > SIDE_W'(MAX_SIDE)) begin
			side_new = SIDE_W'(MAX_SIDE);
		end else begin
			side_new = maze_size_q;
		end
	end

	// Neighbor range and visited checks around the cursor.
	always_comb begin
		x_ext = {1'b0, x_q};
		y_ext = {1'b0, y_q};
		in_rng[DIR_UP] = (y_q != '0);
		in_rng[DIR_RIGHT] = ((x_ext + SIDE_W'(1)) < side_q);
		in_rng[DIR_DOWN] = ((y_ext + SIDE_W'(1)) < side_q);
		in_rng[DIR_LEFT] = (x_q != '0);
		seen[DIR_UP] = up_q;
		seen[DIR_RIGHT] = row_q[x_q + COORD_W'(1)];
		seen[DIR_DOWN] = down_q;
		seen[DIR_LEFT] = row_q[x_q - COORD_W'(1)];
		free = in_rng & ~seen;
		at_start = (x_q == side_q[SIDE_W-1:1]) && (y_q == '0);
		row_set = row_q | (MAX_SIDE'(1) << x_q);
		carve_cell = step_cell(dir_q, x_q, y_q);
		back_dir = dir_t'(bp_rdata);
		back_cell = step_cell(back_dir, x_q, y_q);
	end

	// Outcome of the item being finished.
	always_comb begin
		nxt_x = x_q;
		nxt_y = y_q;
		nxt_fin = fin_q;
		nxt_kind = EV_DONE;
		nxt_wv = 1'b0;
		nxt_wx = '0;
		nxt_wy = '0;
		mark_cur = 1'b0;
		write_bp = 1'b0;
		if (op_q == OP_STEP && !fin_q) begin
			if (free == '0) begin
				// Dead end: mark the cell and either finish or walk back.
				mark_cur = 1'b1;
				if (at_start) begin
					nxt_fin = 1'b1;
				end else begin
					nxt_kind = EV_BACKTRACK;
					if (in_rng[back_dir]) begin
						{nxt_y, nxt_x} = back_cell;
					end
				end
			end else if (!free[dir_q]) begin
				nxt_kind = EV_REJECTED;
			end else begin
				// Carve into the drawn neighbor and leave a pointer back.
				nxt_kind = EV_CARVED;
				mark_cur = 1'b1;
				write_bp = 1'b1;
				{nxt_y, nxt_x} = carve_cell;
				case (dir_q)
					DIR_UP: begin
						nxt_wx = x_q;
						nxt_wy = y_q;
					end
					DIR_RIGHT: begin
						nxt_wv = 1'b1;
						{nxt_wy, nxt_wx} = carve_cell;
					end
					DIR_DOWN: begin
						{nxt_wy, nxt_wx} = carve_cell;
					end
					default: begin
						nxt_wv = 1'b1;
						nxt_wx = x_q;
						nxt_wy = y_q;
					end
				endcase
			end
		end
	end

	// Visited rows: one 64-bit row per grid row, cleared by a sweep.
	always_comb begin
		unique case (cmd.rsel)
			RS_UP:   vis_raddr = y_q - COORD_W'(1);
			RS_DOWN: vis_raddr = y_q + COORD_W'(1);
			default: vis_raddr = y_q;
		endcase
		vis_we = cmd.clear_wr || (cmd.commit && mark_cur);
		vis_waddr = cmd.clear_wr ? clr_q : y_q;
		vis_wdata = cmd.clear_wr ? '0 : row_set;
	end

	mdc_ram #(
		.WIDTH(MAX_SIDE),
		.DEPTH(MAX_SIDE)
	) u_visited (
		.clk  (clk),
		.we   (vis_we),
		.waddr(vis_waddr),
		.wdata(vis_wdata),
		.raddr(vis_raddr),
		.rdata(vis_rdata)
	);

	// Back-pointers, one per cell.
	mdc_ram #(
		.WIDTH(2),
		.DEPTH(CELLS)
	) u_back_ptr (
		.clk  (clk),
		.we   (cmd.commit && write_bp),
		.waddr(carve_cell),
		.wdata(dir_q ^ DIR_DOWN),
		.raddr({y_q, x_q}),
		.rdata(bp_rdata)
	);

	// Control state: configuration, cursor, flag and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			maze_size_q <= SIDE_W'(SIDE_RESET);
			side_q <= SIDE_W'(SIDE_RESET);
			x_q <= COORD_W'(SIDE_RESET / 2);
			y_q <= '0;
			fin_q <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				maze_size_q <= cfg_maze_size;
			end
			if (cmd.init) begin
				side_q <= side_new;
				x_q <= side_new[SIDE_W-1:1];
				y_q <= '0;
				fin_q <= 1'b0;
			end else if (cmd.commit) begin
				x_q <= nxt_x;
				y_q <= nxt_y;
				fin_q <= nxt_fin;
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers; the result fields hold while the transaction waits.
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			op_q <= operation;
			dir_q <= dir_t'(random_direction);
		end
		if (cmd.init) begin
			clr_q <= '0;
		end else if (cmd.clear_wr) begin
			clr_q <= clr_q + COORD_W'(1);
		end
		if (cmd.cap_cur) begin
			row_q <= vis_rdata;
		end
		if (cmd.cap_up) begin
			up_q <= vis_rdata[x_q];
		end
		if (cmd.cap_down) begin
			down_q <= vis_rdata[x_q];
		end
		if (cmd.commit) begin
			kind_q <= nxt_kind;
			wv_q <= nxt_wv;
			wx_q <= nxt_wx;
			wy_q <= nxt_wy;
			cx_q <= nxt_x;
			cy_q <= nxt_y;
			done_q <= nxt_fin;
		end
	end

	// Status back to the controller.
	always_comb begin
		sts.op_begin = (op_q == OP_BEGIN);
		sts.finished = fin_q;
		sts.clear_last = (clr_q == COORD_W'(MAX_SIDE - 1));
		sts.out_free = !out_valid_q || out_ch.ready;
	end

	// Result transaction.
	assign out_ch.valid = out_valid_q;
	assign out_ch.event_kind = kind_q;
	assign out_ch.wall_vertical = wv_q;
	assign out_ch.wall_x = wx_q;
	assign out_ch.wall_y = wy_q;
	assign out_ch.cursor_x = cx_q;
	assign out_ch.cursor_y = cy_q;
	assign out_ch.done_res = done_q;
endmodule
